// ===== src/sdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlp_pkg
// Types and codes shared by the switch debounce / long-press unit.
// ----------------------------------------------------------------------------
package sdlp_pkg;

	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [IDX_W-1:0] REG_SWITCH_ID  = 2'd2;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [7:0]  SWITCH_ID_RST  = 8'd0;

	// event kinds
	localparam logic [1:0] EV_PRESSED  = 2'd0;
	localparam logic [1:0] EV_LONG     = 2'd1;
	localparam logic [1:0] EV_RELEASED = 2'd2;

	// phase codes
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DEB_DOWN = 3'd1;
	localparam logic [2:0] PH_PRESSED  = 3'd2;
	localparam logic [2:0] PH_LONG     = 3'd3;
	localparam logic [2:0] PH_DEB_UP   = 3'd4;

	typedef struct packed {
		logic        pin_level;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] event_time;
		logic [7:0]  event_switch;
	} out_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [7:0]  switch_id;
	} cfg_t;

	typedef struct packed {
		logic valid;
		out_t word;
	} evt_t;

endpackage

// ===== src/sdlp_core.sv =====
// ----------------------------------------------------------------------------
// sdlp_core
// Phase machine and time mark; steps once per poll and reports its event.
// ----------------------------------------------------------------------------
module sdlp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  sdlp_pkg::in_t  poll,
	input  sdlp_pkg::cfg_t cfg,
	output sdlp_pkg::evt_t evt
);
	import sdlp_pkg::*;

	logic [2:0]  phase_q;
	logic [31:0] mark_q;
	logic [2:0]  phase_d;
	logic        mark_load;
	logic        active;
	logic [31:0] elapsed;
	logic        deb_done;
	logic        long_done;

	assign active    = ~poll.pin_level;
	assign elapsed   = poll.now_ms - mark_q;
	assign deb_done  = elapsed >= {16'd0, cfg.debounce_ms};
	assign long_done = elapsed >= {16'd0, cfg.long_press_ms};

	always_comb begin
		phase_d                = phase_q;
		mark_load              = 1'b0;
		evt.valid              = 1'b0;
		evt.word.event_kind    = EV_PRESSED;
		evt.word.event_time    = poll.now_ms;
		evt.word.event_switch  = cfg.switch_id;
		unique case (phase_q)
			PH_DEB_DOWN: begin
				if (!active) begin
					phase_d = PH_IDLE;
				end else if (deb_done) begin
					phase_d             = PH_PRESSED;
					mark_load           = 1'b1;
					evt.valid           = 1'b1;
					evt.word.event_kind = EV_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (active && long_done) begin
					// mark stays put on entry to long pressed
					phase_d             = PH_LONG;
					evt.valid           = 1'b1;
					evt.word.event_kind = EV_LONG;
				end else if (!active) begin
					phase_d   = PH_DEB_UP;
					mark_load = 1'b1;
				end
			end
			PH_LONG: begin
				if (!active) begin
					phase_d   = PH_DEB_UP;
					mark_load = 1'b1;
				end
			end
			PH_DEB_UP: begin
				if (active) begin
					// bounce: back to pressed, restart timing
					phase_d   = PH_PRESSED;
					mark_load = 1'b1;
				end else if (deb_done) begin
					phase_d             = PH_IDLE;
					mark_load           = 1'b1;
					evt.valid           = 1'b1;
					evt.word.event_kind = EV_RELEASED;
				end
			end
			default: begin
				// idle, and unused codes act as idle
				if (active) begin
					phase_d   = PH_DEB_DOWN;
					mark_load = 1'b1;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mark_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (mark_load) begin
				mark_q <= poll.now_ms;
			end
		end
	end

endmodule

// ===== src/switch_debounce_long_press_unit.sv =====
// ----------------------------------------------------------------------------
// switch_debounce_long_press_unit
// Debounces an active-low switch polled with a millisecond time stamp and
// reports pressed, long-pressed and released events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | pin_level, now_ms
//  out     | output    | out_valid / out_ready| event_kind, event_time, switch
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
//  One poll per cycle sustained while the result register is free or being
//  taken; an accepted poll goes into the input register, and its event word,
//  if any, goes into the result register once the result register is free.
//  The phase update is one combinational 32-bit subtract and two compares.
//  Reset clears the phase to idle, the time mark to zero and the registers to
//  their defaults. A stalled result holds the input register; in_ready stays
//  high while the input register is empty or the result register is free or
//  being taken.
// ----------------------------------------------------------------------------
module switch_debounce_long_press_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sdlp_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sdlp_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [sdlp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [sdlp_pkg::CFG_W-1:0]    cfg_wdata
);
	import sdlp_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	in_t  poll_s1;
	logic out_valid_q;
	out_t out_q;
	evt_t evt;
	logic out_free;
	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.switch_id     <= SWITCH_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_wdata;
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_wdata;
				REG_SWITCH_ID:  cfg_q.switch_id     <= cfg_wdata[7:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			poll_s1 <= in_data;
		end
	end

	sdlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.poll   (poll_s1),
		.cfg    (cfg_q),
		.evt    (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt.valid) begin
			out_q <= evt.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/sdlp_checker.sv =====
// ----------------------------------------------------------------------------
// sdlp_checker
// Port-level checks on the switch debounce / long-press unit.
// ----------------------------------------------------------------------------
module sdlp_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  sdlp_pkg::out_t             out_data,
	input  logic                       cfg_we,
	input  logic [sdlp_pkg::IDX_W-1:0] cfg_index,
	input  logic [sdlp_pkg::CFG_W-1:0] cfg_wdata
);
	import sdlp_pkg::*;

	logic       seen_q;
	logic [1:0] last_kind_q;
	logic [7:0] id_q;
	logic       out_take;

	assign out_take = out_valid && out_ready;

	// track the last delivered kind and the last written switch id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_kind_q <= EV_RELEASED;
			id_q        <= SWITCH_ID_RST;
		end else begin
			if (out_take) begin
				seen_q      <= 1'b1;
				last_kind_q <= out_data.event_kind;
			end
			if (cfg_we && cfg_index == REG_SWITCH_ID) begin
				id_q <= cfg_wdata[7:0];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_rise_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a poll two cycles earlier");

	a_press_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && out_data.event_kind == EV_PRESSED
		|-> !seen_q || last_kind_q == EV_RELEASED)
		else $error("pressed event not preceded by release");

	a_release_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && out_data.event_kind == EV_RELEASED
		|-> seen_q && (last_kind_q == EV_PRESSED || last_kind_q == EV_LONG))
		else $error("released event without an earlier press");

	a_switch_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_switch == id_q)
		else $error("event carries a stale switch id");

endmodule

bind switch_debounce_long_press_unit sdlp_checker u_sdlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata)
);
